@@ hw/rtl/bsic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsic_pkg
// Types and constants shared by the book sequence integrity checker.
// ----------------------------------------------------------------------------
package bsic_pkg;

    // table size and derived address width
    localparam int NUM_SYMBOLS = 1024;
    localparam int ADDR_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    // fixed field widths
    localparam int SYM_W = 10;
    localparam int SEQ_W = 63;
    localparam int CRC_W = 32;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    typedef logic [ADDR_W-1:0] t_addr;

    // verdict codes
    typedef enum logic [1:0] {
        VERDICT_OK           = 2'd0,
        VERDICT_CRC_MISMATCH = 2'd1,
        VERDICT_GAP          = 2'd2,
        VERDICT_DROPPED      = 2'd3
    } t_verdict;

    // control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // one table entry: invalid mark, no-sequence mark, last sequence
    typedef struct packed {
        logic             invalid;
        logic             none;
        logic [SEQ_W-1:0] seq;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{invalid: 1'b0, none: 1'b1, seq: SEQ_MAX};

    // one update request
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_snapshot;
        logic             seq_present;
        logic [SEQ_W-1:0] seq;
        logic             checksum_present;
        logic [CRC_W-1:0] computed_crc;
        logic [CRC_W-1:0] venue_crc;
    } t_req;

    // one result
    typedef struct packed {
        logic             accepted;
        logic [1:0]       verdict;
        logic [SEQ_W-1:0] report_first;
        logic [SEQ_W-1:0] report_second;
        logic             resync_request;
    } t_rsp;

endpackage

@@ hw/rtl/bsic_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsic_req_if / bsic_rsp_if
// Valid/ready channels for update requests and their results.
// ----------------------------------------------------------------------------
interface bsic_req_if;
    import bsic_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             is_snapshot;
    logic             seq_present;
    logic [SEQ_W-1:0] seq;
    logic             checksum_present;
    logic [CRC_W-1:0] computed_crc;
    logic [CRC_W-1:0] venue_crc;

    modport source (
        output valid, symbol, is_snapshot, seq_present, seq,
               checksum_present, computed_crc, venue_crc,
        input  ready
    );

    modport sink (
        input  valid, symbol, is_snapshot, seq_present, seq,
               checksum_present, computed_crc, venue_crc,
        output ready
    );
endinterface

interface bsic_rsp_if;
    import bsic_pkg::*;

    logic             valid;
    logic             ready;
    logic             accepted;
    logic [1:0]       verdict;
    logic [SEQ_W-1:0] report_first;
    logic [SEQ_W-1:0] report_second;
    logic             resync_request;

    modport source (
        output valid, accepted, verdict, report_first, report_second, resync_request,
        input  ready
    );

    modport sink (
        input  valid, accepted, verdict, report_first, report_second, resync_request,
        output ready
    );
endinterface

@@ hw/rtl/book_sequence_integrity_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// book_sequence_integrity_checker_top
// Per-symbol sequence gap and snapshot checksum checker over one table memory.
// ----------------------------------------------------------------------------
// Flow: an accepted request and its table entry are registered; the lookup
// state then stores the result in o_rsp or, while o_rsp is held, the skid slot.
// Requests are taken only when idle with the skid slot empty, so not in lookup.
// Reset: after i_rst_n rises a clearing pass writes every one of the
// NUM_SYMBOLS (1024) entries, one a cycle; no request is taken until it ends.
module book_sequence_integrity_checker_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsic_req_if.sink          i_req,
    bsic_rsp_if.source        o_rsp
);
    import bsic_pkg::*;

    localparam t_addr LAST_ADDR = t_addr'(NUM_SYMBOLS - 1);

    // table memory
    t_entry r_mem [NUM_SYMBOLS];

    t_state r_state, n_state;
    t_addr  r_clr_addr, n_clr_addr;
    t_req   r_item;
    t_entry r_rd;
    t_rsp   r_out, n_out;
    t_rsp   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    logic   r_pend_valid, n_pend_valid;

    logic   w_accept;
    logic   w_taken;
    logic   w_we;
    t_addr  w_wr_addr;
    t_entry w_wr_data;
    logic   w_load;

    // lookup results
    logic             w_oor;
    logic             w_upd_we;
    t_entry           w_upd_data;
    t_rsp             w_res;
    logic [SEQ_W-1:0] w_expected;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_taken  = o_rsp.valid && o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            ST_IDLE:   if (w_accept) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_wr_addr   = r_clr_addr;
        w_wr_data   = ENTRY_RESET;
        n_clr_addr  = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + t_addr'(1);
            end
            ST_IDLE: begin
                i_req.ready = !r_pend_valid;
            end
            ST_LOOKUP: begin
                w_load    = 1'b1;
                w_we      = w_upd_we;
                w_wr_addr = t_addr'(r_item.symbol);
                w_wr_data = w_upd_data;
            end
            default: ;
        endcase
    end

    // update rules on the entry just read
    always_comb begin
        w_oor      = 32'(r_item.symbol) >= 32'(NUM_SYMBOLS);
        w_expected = (r_rd.seq == SEQ_MAX) ? SEQ_MAX : r_rd.seq + SEQ_W'(1);
        w_upd_we   = 1'b0;
        w_upd_data = '{invalid: 1'b1, none: 1'b1, seq: SEQ_MAX};
        w_res      = '{accepted: 1'b1, verdict: VERDICT_OK, report_first: '0,
                       report_second: '0, resync_request: 1'b0};
        priority if (w_oor) begin
            w_res.accepted = 1'b0;
            w_res.verdict  = VERDICT_DROPPED;
        end else if (r_item.is_snapshot) begin
            w_upd_we = 1'b1;
            if (r_item.checksum_present && r_item.computed_crc != r_item.venue_crc) begin
                w_res.accepted       = 1'b0;
                w_res.verdict        = VERDICT_CRC_MISMATCH;
                w_res.report_first   = SEQ_W'(r_item.computed_crc);
                w_res.report_second  = SEQ_W'(r_item.venue_crc);
                w_res.resync_request = 1'b1;
            end else begin
                w_upd_data = '{invalid: 1'b0, none: !r_item.seq_present, seq: r_item.seq};
            end
        end else if (r_rd.invalid) begin
            w_res.accepted = 1'b0;
            w_res.verdict  = VERDICT_DROPPED;
        end else if (r_item.seq_present && !r_rd.none && r_item.seq != w_expected) begin
            // sequence gap
            w_upd_we             = 1'b1;
            w_res.accepted       = 1'b0;
            w_res.verdict        = VERDICT_GAP;
            w_res.report_first   = w_expected;
            w_res.report_second  = r_item.seq;
            w_res.resync_request = 1'b1;
        end else if (r_item.seq_present) begin
            w_upd_we   = 1'b1;
            w_upd_data = '{invalid: 1'b0, none: 1'b0, seq: r_item.seq};
        end else begin
            // delta without sequence keeps the entry
            w_upd_we = 1'b0;
        end
    end

    // output register with one skid slot
    always_comb begin
        n_out        = r_out;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_pend_valid = r_pend_valid;
        if (w_load) begin
            if (!r_out_valid || w_taken) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
            end else begin
                n_pend       = w_res;
                n_pend_valid = 1'b1;
            end
        end else if (w_taken) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        if (w_accept) begin
            r_item.symbol           <= i_req.symbol;
            r_item.is_snapshot      <= i_req.is_snapshot;
            r_item.seq_present      <= i_req.seq_present;
            r_item.seq              <= i_req.seq;
            r_item.checksum_present <= i_req.checksum_present;
            r_item.computed_crc     <= i_req.computed_crc;
            r_item.venue_crc        <= i_req.venue_crc;
        end
    end

    // table read on accept, write on clear or write-back
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_mem[t_addr'(i_req.symbol)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // result port
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_out.accepted;
    assign o_rsp.verdict        = r_out.verdict;
    assign o_rsp.report_first   = r_out.report_first;
    assign o_rsp.report_second  = r_out.report_second;
    assign o_rsp.resync_request = r_out.resync_request;

    // checks
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("table write while idle");

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("skid slot full with output empty");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOOKUP))
        else $error("accepted request not looked up");

    a_resync_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.resync_request) |->
        (o_rsp.verdict == VERDICT_GAP || o_rsp.verdict == VERDICT_CRC_MISMATCH))
        else $error("resync without gap or mismatch");

    a_lookup_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP) |-> !r_pend_valid)
        else $error("lookup with no room for its result");

endmodule

@@ tb/sv/bsic_update_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsic_update_checker
// Watches the request and result channels of the book sequence integrity
// checker, keeps its own per-symbol copy of the last sequence and invalid
// mark, works out the result of every accepted request and compares each
// returned result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module bsic_update_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bsic_req_if  i_req,
    bsic_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import bsic_pkg::*;

    // per-symbol book state
    logic             book_bad  [NUM_SYMBOLS];
    logic             seq_known [NUM_SYMBOLS];
    logic [SEQ_W-1:0] seq_last  [NUM_SYMBOLS];

    // results still owed by the block, oldest first
    t_rsp outcome_q [$];

    // one line per mismatch, printing capped so a broken block stays readable
    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        if (o_fail_count < 100) begin
            $display("%0t bsic_update_checker: %s got 0x%0h expected 0x%0h",
                     $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // judge one update against the book state and advance that state
    function automatic t_rsp judge_update(input t_req u);
        t_rsp             r;
        t_addr            idx;
        logic [SEQ_W-1:0] want_seq;
        r = '0;
        r.verdict = VERDICT_OK;
        if (int'(u.symbol) >= NUM_SYMBOLS) begin
            r.verdict = VERDICT_DROPPED;
            return r;
        end
        idx = t_addr'(u.symbol);

        // snapshot: checksum test, otherwise restart the book
        if (u.is_snapshot) begin
            if (u.checksum_present && u.computed_crc != u.venue_crc) begin
                seq_known[idx]   = 1'b0;
                book_bad[idx]    = 1'b1;
                r.verdict        = VERDICT_CRC_MISMATCH;
                r.report_first   = SEQ_W'(u.computed_crc);
                r.report_second  = SEQ_W'(u.venue_crc);
                r.resync_request = 1'b1;
            end else begin
                seq_known[idx] = u.seq_present;
                seq_last[idx]  = u.seq;
                book_bad[idx]  = 1'b0;
                r.accepted     = 1'b1;
            end
            return r;
        end

        // delta on a book waiting for a snapshot
        if (book_bad[idx]) begin
            r.verdict = VERDICT_DROPPED;
            return r;
        end

        // continuity test, next expected saturates at the top of the range
        if (u.seq_present && seq_known[idx]) begin
            want_seq = (seq_last[idx] == SEQ_MAX) ? SEQ_MAX : seq_last[idx] + 1'b1;
            if (u.seq != want_seq) begin
                seq_known[idx]   = 1'b0;
                book_bad[idx]    = 1'b1;
                r.verdict        = VERDICT_GAP;
                r.report_first   = want_seq;
                r.report_second  = u.seq;
                r.resync_request = 1'b1;
                return r;
            end
        end
        if (u.seq_present) begin
            seq_known[idx] = 1'b1;
            seq_last[idx]  = u.seq;
        end
        r.accepted = 1'b1;
        return r;
    endfunction

    // results are compared before new requests are queued at the same edge
    always @(posedge i_clk) begin
        t_req upd;
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                book_bad[k]  = 1'b0;
                seq_known[k] = 1'b0;
                seq_last[k]  = SEQ_MAX;
            end
            outcome_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.accepted       = i_rsp.accepted;
                got.verdict        = i_rsp.verdict;
                got.report_first   = i_rsp.report_first;
                got.report_second  = i_rsp.report_second;
                got.resync_request = i_rsp.resync_request;
                if (outcome_q.size() == 0) begin
                    report_mismatch("result with no request outstanding, verdict",
                                    SEQ_W'(got.verdict), '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", SEQ_W'(got.accepted),
                                        SEQ_W'(want.accepted));
                    if (got.verdict !== want.verdict)
                        report_mismatch("verdict", SEQ_W'(got.verdict),
                                        SEQ_W'(want.verdict));
                    if (got.report_first !== want.report_first)
                        report_mismatch("report_first", got.report_first,
                                        want.report_first);
                    if (got.report_second !== want.report_second)
                        report_mismatch("report_second", got.report_second,
                                        want.report_second);
                    if (got.resync_request !== want.resync_request)
                        report_mismatch("resync_request", SEQ_W'(got.resync_request),
                                        SEQ_W'(want.resync_request));
                end
            end
            if (i_req.valid && i_req.ready) begin
                upd.symbol           = i_req.symbol;
                upd.is_snapshot      = i_req.is_snapshot;
                upd.seq_present      = i_req.seq_present;
                upd.seq              = i_req.seq;
                upd.checksum_present = i_req.checksum_present;
                upd.computed_crc     = i_req.computed_crc;
                upd.venue_crc        = i_req.venue_crc;
                outcome_q.push_back(judge_update(upd));
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

@@ tb/sv/book_sequence_integrity_checker_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// book_sequence_integrity_checker_top_tb
// Drives order book updates into the checker: a directed run over gaps,
// checksum mismatches, dropped deltas and sequence saturation, then random
// per-symbol streams that are mostly in order with gaps, replays, resyncs
// and noise mixed in. Both channels idle at random and the result side
// holds off once for a long stretch. Checking is done by bsic_update_checker.
// ----------------------------------------------------------------------------
module book_sequence_integrity_checker_top_tb;
    import bsic_pkg::*;

    localparam int HOT_SYMBOLS     = 16;
    localparam int RANDOM_UPDATES  = 2000;
    localparam int HOLD_OFF_AT     = 600;
    localparam int HOLD_OFF_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   updates_sent;

    bsic_req_if req_bus ();
    bsic_rsp_if rsp_bus ();

    book_sequence_integrity_checker_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    bsic_update_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        #12_000_000;
        $display("book_sequence_integrity_checker_top_tb: FAIL");
        $finish;
    end

    function automatic t_req mk_update(input logic [SYM_W-1:0] sym, input bit snap,
                                       input bit has_seq, input logic [SEQ_W-1:0] seq,
                                       input bit has_cs, input logic [CRC_W-1:0] comp,
                                       input logic [CRC_W-1:0] venue);
        t_req u;
        u.symbol           = sym;
        u.is_snapshot      = snap;
        u.seq_present      = has_seq;
        u.seq              = seq;
        u.checksum_present = has_cs;
        u.computed_crc     = comp;
        u.venue_crc        = venue;
        return u;
    endfunction

    // sequence numbers spread over small, near-top and full-range values
    function automatic logic [SEQ_W-1:0] rand_seq();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return SEQ_W'($urandom_range(0, 1000));
            1: return SEQ_MAX - SEQ_W'($urandom_range(0, 3));
            default: return r[SEQ_W-1:0];
        endcase
    endfunction

    function automatic logic [SEQ_W-1:0] next_after(input logic [SEQ_W-1:0] s);
        return (s == SEQ_MAX) ? SEQ_MAX : s + 1'b1;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_update(input t_req u);
        @(negedge i_clk);
        req_bus.valid            <= 1'b1;
        req_bus.symbol           <= u.symbol;
        req_bus.is_snapshot      <= u.is_snapshot;
        req_bus.seq_present      <= u.seq_present;
        req_bus.seq              <= u.seq;
        req_bus.checksum_present <= u.checksum_present;
        req_bus.computed_crc     <= u.computed_crc;
        req_bus.venue_crc        <= u.venue_crc;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        updates_sent++;
    endtask

    // idle the request side with junk on the payload
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            req_bus.valid            <= 1'b0;
            req_bus.symbol           <= SYM_W'($urandom);
            req_bus.is_snapshot      <= 1'($urandom);
            req_bus.seq_present      <= 1'($urandom);
            req_bus.seq              <= SEQ_W'({$urandom, $urandom});
            req_bus.checksum_present <= 1'($urandom);
            req_bus.computed_crc     <= $urandom;
            req_bus.venue_crc        <= $urandom;
        end
    endtask

    // result side: bursts of ready, random stalls, one long hold-off
    initial begin : rsp_drain
        logic held;
        int   span;
        held          = 1'b0;
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && updates_sent >= HOLD_OFF_AT) begin
                held = 1'b1;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    rsp_bus.ready <= 1'b0;
                end
            end else if ($urandom_range(0, 2) == 0) begin
                span = pick_gap();
                if (span == 0) span = 1;
                repeat (span) begin
                    @(negedge i_clk);
                    rsp_bus.ready <= 1'b0;
                end
            end else begin
                span = $urandom_range(1, 24);
                repeat (span) begin
                    @(negedge i_clk);
                    rsp_bus.ready <= 1'b1;
                end
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        t_req             u;
        t_req             directed_q [$];
        logic [SYM_W-1:0] hot [HOT_SYMBOLS];
        logic [SEQ_W-1:0] seq_hint [1 << SYM_W];
        logic [SYM_W-1:0] s;
        logic [CRC_W-1:0] crc;
        logic             calm;
        bit               has_cs;
        int               kind;

        req_bus.valid            = 1'b0;
        req_bus.symbol           = '0;
        req_bus.is_snapshot      = 1'b0;
        req_bus.seq_present      = 1'b0;
        req_bus.seq              = '0;
        req_bus.checksum_present = 1'b0;
        req_bus.computed_crc     = '0;
        req_bus.venue_crc        = '0;
        updates_sent             = 0;
        i_rst_n                  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // delta stream on symbol 0: first delta with no history, gap, drop
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd5, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd6, 1, 32'd1, 32'd2));
        directed_q.push_back(mk_update(10'd0, 0, 0, 63'd99, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd7, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd9, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd10, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd0, 1, 1, 63'd100, 1, 32'h1234, 32'h1234));
        directed_q.push_back(mk_update(10'd0, 0, 1, 63'd101, 0, 32'd0, 32'd0));
        // top symbol: checksum mismatch, drop, unchecked snapshot at the top
        directed_q.push_back(mk_update(10'd1023, 1, 1, 63'd3, 1, 32'hFFFF_FFFF, 32'd0));
        directed_q.push_back(mk_update(10'd1023, 0, 1, 63'd4, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd1023, 1, 1, SEQ_MAX, 0, 32'd1, 32'd2));
        directed_q.push_back(mk_update(10'd1023, 0, 1, SEQ_MAX, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd1023, 0, 1, 63'd0, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd1023, 1, 0, SEQ_MAX, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd1023, 0, 1, 63'd0, 0, 32'd0, 32'd0));
        // mid symbol: matching checksum, gap to the top, mismatch, saturation
        directed_q.push_back(mk_update(10'd512, 1, 1, 63'd0, 1, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF));
        directed_q.push_back(mk_update(10'd512, 0, 1, SEQ_MAX, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd512, 1, 1, 63'd8, 1, 32'd0, 32'hFFFF_FFFF));
        directed_q.push_back(mk_update(10'd512, 1, 1, SEQ_MAX - 1, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd512, 0, 1, SEQ_MAX, 0, 32'd0, 32'd0));
        directed_q.push_back(mk_update(10'd512, 0, 1, SEQ_MAX, 0, 32'd0, 32'd0));
        foreach (directed_q[i]) begin
            send_update(directed_q[i]);
            idle_sender(pick_gap());
        end

        // random streams, mostly on a few busy symbols
        for (int i = 0; i < HOT_SYMBOLS; i++) hot[i] = SYM_W'($urandom);
        for (int i = 0; i < (1 << SYM_W); i++) seq_hint[i] = '0;
        for (int n = 0; n < RANDOM_UPDATES; n++) begin
            calm = ((n / 150) % 3 == 1);
            s    = ($urandom_range(0, 9) == 0) ? SYM_W'($urandom)
                                               : hot[$urandom_range(0, HOT_SYMBOLS - 1)];
            kind = $urandom_range(0, 99);
            crc  = $urandom;
            if (kind < 10) begin
                // clean snapshot, checksum matching or absent
                has_cs = 1'($urandom);
                u = mk_update(s, 1, 1, rand_seq(), has_cs, crc, has_cs ? crc : $urandom);
                seq_hint[s] = next_after(u.seq);
            end else if (kind < 14) begin
                // snapshot with a bad checksum
                u = mk_update(s, 1, 1'($urandom), rand_seq(), 1, crc,
                              crc ^ ($urandom | 32'h1));
            end else if (kind < 17) begin
                // snapshot with no sequence
                u = mk_update(s, 1, 0, rand_seq(), 1'($urandom), crc, crc);
                seq_hint[s] = rand_seq();
            end else if (kind < 77) begin
                // in-order delta
                u = mk_update(s, 0, 1, seq_hint[s], 1'($urandom), crc, $urandom);
                seq_hint[s] = next_after(seq_hint[s]);
            end else if (kind < 85) begin
                // out-of-order delta: skip ahead, replay or jump
                case ($urandom_range(0, 2))
                    0: u = mk_update(s, 0, 1, seq_hint[s] + SEQ_W'($urandom_range(1, 5)),
                                     0, crc, crc);
                    1: u = mk_update(s, 0, 1, seq_hint[s] - 1'b1, 0, crc, crc);
                    default: u = mk_update(s, 0, 1, rand_seq(), 0, crc, crc);
                endcase
            end else if (kind < 91) begin
                // delta with no sequence
                u = mk_update(s, 0, 0, rand_seq(), 1'($urandom), crc, $urandom);
            end else begin
                // noise
                u = mk_update(SYM_W'($urandom), 1'($urandom), 1'($urandom), rand_seq(),
                              1'($urandom), crc, $urandom);
            end
            send_update(u);
            if (!calm) idle_sender(pick_gap());
        end

        // drain and let the pipeline settle
        idle_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("book_sequence_integrity_checker_top_tb: PASS");
        end else begin
            $display("book_sequence_integrity_checker_top_tb: FAIL");
        end
        $finish;
    end

endmodule
